// File: design/event_pixel_intensity_integrator_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the event pixel intensity integrator
// Assertion wrappers used by epii_ctrl; define ASSERT_OFF to compile them away.
// ----------------------------------------------------------------------------
`ifndef EVENT_PIXEL_INTENSITY_INTEGRATOR_CORE_DEFINES_SVH
`define EVENT_PIXEL_INTENSITY_INTEGRATOR_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication.
`define EPII_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("epii assertion failed");
// Next-cycle implication.
`define EPII_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("epii assertion failed");
`else
`define EPII_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EPII_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/epii_pkg.sv
// ----------------------------------------------------------------------------
// epii_pkg
// Types, constants and exponent tables of the pixel intensity integrator.
// ----------------------------------------------------------------------------
package epii_pkg;

	localparam int COLS_DEF = 256;
	localparam int ROWS_DEF = 256;
	localparam int CFG_W    = 24;

	// Register reset values.
	localparam logic [11:0] CONTRAST_RST = 12'd614;
	localparam logic [23:0] LEAK_RST     = 24'd21475;
	localparam logic [15:0] GAIN_RST     = 16'd2458;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_CONTRAST = 2'd0,
		REG_LEAK     = 2'd1,
		REG_GAIN     = 2'd2
	} cfg_reg_t;

	// Controller states.
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_READ, S_LOAD, S_MULX, S_INITF, S_FRAC,
		S_SCALE, S_APPLY, S_EVENT, S_RMUL, S_RVAL, S_OUT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_we;
		logic capture;
		logic mem_rd;
		logic load_rd;
		logic mul_x;
		logic init_f;
		logic frac_step;
		logic scale;
		logic apply;
		logic ev_write;
		logic r_mul;
		logic r_write;
		logic load_out;
		logic out_oor;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic in_range;
		logic is_render;
		logic frac_last;
	} stat_t;

	// exp(-n) in Q1.16 for the integer part of the exponent.
	function automatic logic [16:0] int_tab(input logic [3:0] n);
		logic [16:0] r;
		case (n)
			4'd0:    r = 17'd65536;
			4'd1:    r = 17'd24109;
			4'd2:    r = 17'd8869;
			4'd3:    r = 17'd3263;
			4'd4:    r = 17'd1200;
			4'd5:    r = 17'd442;
			4'd6:    r = 17'd162;
			4'd7:    r = 17'd60;
			4'd8:    r = 17'd22;
			4'd9:    r = 17'd8;
			4'd10:   r = 17'd3;
			4'd11:   r = 17'd1;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	// exp(-2^-(k+1)) in Q0.16.
	function automatic logic [15:0] frac_tab(input logic [3:0] k);
		logic [15:0] r;
		case (k)
			4'd0:    r = 16'd39749;
			4'd1:    r = 16'd51039;
			4'd2:    r = 16'd57835;
			4'd3:    r = 16'd61565;
			4'd4:    r = 16'd63520;
			4'd5:    r = 16'd64520;
			4'd6:    r = 16'd65026;
			4'd7:    r = 16'd65280;
			4'd8:    r = 16'd65408;
			4'd9:    r = 16'd65472;
			4'd10:   r = 16'd65504;
			4'd11:   r = 16'd65520;
			4'd12:   r = 16'd65528;
			4'd13:   r = 16'd65532;
			4'd14:   r = 16'd65534;
			default: r = 16'd65535;
		endcase
		return r;
	endfunction

endpackage

// File: design/event_pixel_intensity_integrator_core.sv
// ----------------------------------------------------------------------------
// event_pixel_intensity_integrator_core
// Per-pixel leaky-integrator intensity reconstruction for an event sensor.
// ----------------------------------------------------------------------------
// Channel   Handshake              Payload
// config    cfg_we                 cfg_index, cfg_wdata
// input     start && !busy         operation, column, row, time_us, polarity
// result    done (one cycle)       intensity, level
//
// An event or render word in range passes through the 16 serial
// fraction steps of the decay factor; an out-of-range word skips them,
// and a render still returns a result. After reset a clearing pass
// writes every pixel once with busy high. The receiver cannot stall;
// each result word is shown for one cycle.
// ----------------------------------------------------------------------------
module event_pixel_intensity_integrator_core
	import epii_pkg::*;
#(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_wdata,
	input  logic               start,
	output logic               busy,
	input  logic               operation,
	input  logic [7:0]         column,
	input  logic [7:0]         row,
	input  logic [31:0]        time_us,
	input  logic               polarity,
	output logic               done,
	output logic [7:0]         intensity,
	output logic signed [15:0] level
);

	cmd_t  cmd;
	stat_t stat;

	// Sequencer.
	epii_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Arithmetic and pixel store.
	epii_datapath #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.operation (operation),
		.column    (column),
		.row       (row),
		.time_us   (time_us),
		.polarity  (polarity),
		.intensity (intensity),
		.level     (level)
	);

endmodule

// File: design/epii_ctrl.sv
// ----------------------------------------------------------------------------
// epii_ctrl
// Controller state machine: memory clear, per-word sequencing, result strobe.
// ----------------------------------------------------------------------------
`include "event_pixel_intensity_integrator_core_defines.svh"

module epii_ctrl
	import epii_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  stat_t stat,
	output cmd_t  cmd,
	output logic  busy,
	output logic  done
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_we = 1'b1;
				if (stat.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = S_READ;
				end
			end
			S_READ: begin
				cmd.mem_rd = 1'b1;
				if (stat.in_range) begin
					state_d = S_LOAD;
				end else if (stat.is_render) begin
					cmd.load_out = 1'b1;
					cmd.out_oor  = 1'b1;
					state_d      = S_OUT;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_LOAD: begin
				cmd.load_rd = 1'b1;
				state_d     = S_MULX;
			end
			S_MULX: begin
				cmd.mul_x = 1'b1;
				state_d   = S_INITF;
			end
			S_INITF: begin
				cmd.init_f = 1'b1;
				state_d    = S_FRAC;
			end
			S_FRAC: begin
				cmd.frac_step = 1'b1;
				if (stat.frac_last) state_d = S_SCALE;
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_APPLY;
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = stat.is_render ? S_RMUL : S_EVENT;
			end
			S_EVENT: begin
				cmd.ev_write = 1'b1;
				state_d      = S_IDLE;
			end
			S_RMUL: begin
				cmd.r_mul   = 1'b1;
				cmd.r_write = 1'b1;
				state_d     = S_RVAL;
			end
			S_RVAL: begin
				cmd.load_out = 1'b1;
				state_d      = S_OUT;
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_OUT);

	// The result strobe lasts a single cycle.
	`EPII_ASSERT_NXT(a_done_pulse, clk, arst_n, done, !done)
	// An accepted word makes the block busy once the state register leaves idle.
	`EPII_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy)
	// Memory writes run on every cycle of the clearing pass.
	`EPII_ASSERT_IMP(a_clear_we, clk, arst_n, state_q == S_CLEAR, cmd.clear_we)
	// The last fraction step hands over to the scaling step.
	`EPII_ASSERT_NXT(a_frac_end, clk, arst_n, cmd.frac_step && stat.frac_last,
		state_q == S_SCALE)

endmodule

// File: design/epii_datapath.sv
// ----------------------------------------------------------------------------
// epii_datapath
// Pixel memory, configuration registers, decay and display arithmetic.
// ----------------------------------------------------------------------------
module epii_datapath
	import epii_pkg::*;
#(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output stat_t             stat,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              operation,
	input  logic [7:0]        column,
	input  logic [7:0]        row,
	input  logic [31:0]       time_us,
	input  logic              polarity,
	output logic [7:0]        intensity,
	output logic signed [15:0] level
);

	localparam int PIXELS = COLS * ROWS;
	localparam int PIX_W  = $clog2(PIXELS);

	// Configuration registers.
	logic [11:0] contrast_q;
	logic [23:0] leak_q;
	logic [15:0] gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contrast_q <= CONTRAST_RST;
			leak_q     <= LEAK_RST;
			gain_q     <= GAIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CONTRAST: contrast_q <= cfg_wdata[11:0];
				REG_LEAK:     leak_q     <= cfg_wdata[23:0];
				REG_GAIN:     gain_q     <= cfg_wdata[15:0];
				default:      ;
			endcase
		end
	end

	// Clearing pass counter.
	logic [PIX_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear_we) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Captured input word.
	logic             op_q;
	logic             pol_q;
	logic             inr_q;
	logic [31:0]      t_q;
	logic [PIX_W-1:0] idx_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= operation;
			pol_q <= polarity;
			t_q   <= time_us;
			inr_q <= (32'(column) < 32'(COLS)) && (32'(row) < 32'(ROWS));
			idx_q <= PIX_W'(32'(row) * 32'(COLS) + 32'(column));
		end
	end

	// Pixel memory: time in the upper 32 bits, level in the low 16 bits.
	logic [47:0] mem [PIXELS];
	logic [47:0] rd_q;
	logic        we;
	logic [PIX_W-1:0] wa;
	logic [47:0] wd;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (cmd.mem_rd) rd_q <= mem[idx_q];
	end

	// Decay state.
	logic signed [15:0] lvl_q;
	logic               gt_q;
	logic [31:0]        dt_q;
	logic [55:0]        x_q;
	logic [16:0]        f_q;
	logic [3:0]         k_q;
	logic [33:0]        sc_q;
	logic signed [32:0] gl_q;

	logic [32:0] frac_prod;
	logic [16:0] frac_next;
	logic [16:0] mag;
	logic [16:0] dec;
	logic signed [17:0] ev_sum;
	logic signed [15:0] ev_sat;
	logic signed [33:0] v_raw;
	logic [24:0] v_clamp;
	logic [32:0] v_scaled;
	logic [15:0] x_frac_hi;

	always_comb begin
		x_frac_hi = x_q[31:16];
		frac_prod = f_q * frac_tab(k_q) + 33'd32768;
		frac_next = frac_prod[32:16];
		mag       = lvl_q[15] ? (17'd0 - 17'(lvl_q)) : 17'(lvl_q);
		dec       = 17'((sc_q + 34'd32768) >> 16);
		ev_sum    = pol_q ? (18'(lvl_q) + $signed({6'd0, contrast_q}))
			: (18'(lvl_q) - $signed({6'd0, contrast_q}));
		if (ev_sum > 18'sd32767) begin
			ev_sat = 16'sh7fff;
		end else if (ev_sum < -18'sd32768) begin
			ev_sat = 16'sh8000;
		end else begin
			ev_sat = ev_sum[15:0];
		end
		v_raw = 34'sd8388608 + 34'(gl_q);
		if (v_raw < 34'sd0) begin
			v_clamp = '0;
		end else if (v_raw > 34'sd16777216) begin
			v_clamp = 25'd16777216;
		end else begin
			v_clamp = v_raw[24:0];
		end
		v_scaled = ({v_clamp, 8'd0} - 33'(v_clamp)) + 33'd8388608;
	end

	// Decay and display sequence.
	always_ff @(posedge clk) begin
		if (cmd.load_rd) begin
			lvl_q <= rd_q[15:0];
			gt_q  <= t_q > rd_q[47:16];
			dt_q  <= t_q - rd_q[47:16];
		end
		if (cmd.mul_x) x_q <= leak_q * dt_q;
		if (cmd.init_f) begin
			f_q <= (x_q[55:36] != '0) ? 17'd0 : int_tab(x_q[35:32]);
			k_q <= '0;
		end
		if (cmd.frac_step) begin
			if (x_frac_hi[~k_q]) f_q <= frac_next;
			k_q <= k_q + 1'b1;
		end
		if (cmd.scale) sc_q <= mag * f_q;
		if (cmd.apply && gt_q) lvl_q <= lvl_q[15] ? (16'd0 - dec[15:0]) : dec[15:0];
		if (cmd.r_mul) gl_q <= $signed({1'b0, gain_q}) * lvl_q;
		if (cmd.load_out) begin
			if (cmd.out_oor) begin
				intensity <= 8'd128;
				level     <= '0;
			end else begin
				intensity <= v_scaled[31:24];
				level     <= lvl_q;
			end
		end
	end

	// Memory write port selection.
	always_comb begin
		we = 1'b0;
		wa = idx_q;
		wd = {t_q, lvl_q};
		if (cmd.clear_we) begin
			we = 1'b1;
			wa = clr_q;
			wd = '0;
		end else if (cmd.ev_write) begin
			we = 1'b1;
			wd = {t_q, ev_sat};
		end else if (cmd.r_write) begin
			we = gt_q;
		end
	end

	assign stat.clear_last = (clr_q == PIX_W'(PIXELS - 1));
	assign stat.in_range   = inr_q;
	assign stat.is_render  = op_q;
	assign stat.frac_last  = (k_q == 4'd15);

endmodule
